@@ design/fmfp_pkg.sv @@
// Shared types and constants of the framed message field parser.
package fmfp_pkg;

   // Character codes that the parser reacts to.
   localparam logic [7:0] CHR_OPEN  = 8'h3C;  // '<'
   localparam logic [7:0] CHR_CLOSE = 8'h3E;  // '>'
   localparam logic [7:0] CHR_SEP   = 8'h3B;  // ';'
   localparam logic [7:0] CHR_STAR  = 8'h2A;  // '*'
   localparam logic [7:0] CHR_PLUS  = 8'h2B;  // '+'
   localparam logic [7:0] CHR_ZERO  = 8'h30;  // '0'
   localparam logic [7:0] CHR_NINE  = 8'h39;  // '9'
   localparam logic [7:0] CHR_SPACE = 8'h20;
   localparam logic [7:0] CHR_TAB   = 8'h09;  // lowest control code counted as whitespace
   localparam logic [7:0] CHR_CR    = 8'h0D;  // highest control code counted as whitespace

   // Request item layout: character in the low byte, signal strength above it.
   localparam int REQ_DATA_W = 24;

   // Result fields other than the field count: ok, matched, date-time, strength.
   localparam int RSP_FIXED_W = 66;

   // Date fields 1 to 5 of a frame, and the four 8-bit parts after the year.
   localparam int DATE_FIELDS = 5;
   localparam int DATE_PARTS  = 4;

   // Depth of the queue between the classifier and the parser.
   localparam int QUEUE_DEPTH = 4;

   // Register file.
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 64;
   localparam logic REG_TAG_PATTERN = 1'b0;
   localparam logic REG_TAG_LENGTH  = 1'b1;
   localparam logic [63:0] TAG_PATTERN_RESET = 64'h003D_2A54_2A43_2323;
   localparam logic [3:0]  TAG_LENGTH_RESET  = 4'd7;

   // Character classes found by the front end.
   typedef enum logic [2:0] {
      CLS_SPACE,
      CLS_OPEN,
      CLS_CLOSE,
      CLS_SEP,
      CLS_DIGIT,
      CLS_PLUS,
      CLS_OTHER
   } char_class_type;

   // One classified character on its way to the parser.
   typedef struct packed {
      logic [7:0]          chr;
      char_class_type      cls;
      logic                last;
      logic signed [15:0]  strength;
   } token_type;

   // Configuration seen by the parser.
   typedef struct packed {
      logic [63:0] pattern;
      logic [3:0]  pattern_len;
   } cfg_type;

endpackage

@@ design/framed_message_field_parser_unit.sv @@
// The result item is registered: the item with the last character goes through the character
// queue, and the result register is loaded when that character is popped from its head.
// The parser retires one queued character per cycle; a last one waits for a free result register.
// The four-entry character queue and the result register let either side stall on its own.
// Reset (synchronous, active high) empties the queue, clears the frame and the stored
// date-time, and loads the tag pattern "##C*T*=" with length 7.
module framed_message_field_parser_unit #(
   parameter int MAX_FIELDS    = 16,
   parameter int FIELD_BUFFER  = 16,
   parameter int PATTERN_CHARS = 8
) (
   input  logic                            clock,
   input  logic                            reset,
   // Request channel
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [fmfp_pkg::REQ_DATA_W-1:0] req_tdata,  // [7:0] character, [23:8] signal_strength
   input  logic                            req_tlast,  // last_char
   // Result channel
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // frame_ok, field_count, tag_matched, year, month, day, hour, minute, strength_echo
   output logic [((fmfp_pkg::RSP_FIXED_W + $clog2(MAX_FIELDS + 1) + 7) / 8) * 8 - 1:0] rsp_tdata,
   // Configuration port
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [fmfp_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [fmfp_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [fmfp_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                            csr_pready
);
   import fmfp_pkg::*;

   localparam int FCW   = $clog2(MAX_FIELDS + 1);
   localparam int OUT_W = ((RSP_FIXED_W + FCW + 7) / 8) * 8;

   logic [63:0] tag_pattern_ff;
   logic [3:0]  tag_length_ff;
   logic        csr_write;
   cfg_type     cfg;
   logic        q_full;
   logic        push;
   token_type   push_token;
   logic        q_valid;
   token_type   q_token;
   logic        q_pop;

   // Register file: address bit 3 selects the register.
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_prdata = (csr_paddr[3] == REG_TAG_LENGTH) ? {60'd0, tag_length_ff} : tag_pattern_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         tag_pattern_ff <= TAG_PATTERN_RESET;
         tag_length_ff  <= TAG_LENGTH_RESET;
      end else if (csr_write) begin
         if (csr_paddr[3] == REG_TAG_PATTERN) begin
            tag_pattern_ff <= csr_pwdata;
         end else begin
            tag_length_ff <= csr_pwdata[3:0];
         end
      end
   end

   assign cfg.pattern     = tag_pattern_ff;
   assign cfg.pattern_len = tag_length_ff;

   fmfp_front u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .q_full     (q_full),
      .push       (push),
      .push_token (push_token)
   );

   fmfp_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_token (push_token),
      .full       (q_full),
      .out_valid  (q_valid),
      .out_token  (q_token),
      .pop        (q_pop)
   );

   fmfp_back #(
      .MAX_FIELDS    (MAX_FIELDS),
      .FIELD_BUFFER  (FIELD_BUFFER),
      .PATTERN_CHARS (PATTERN_CHARS),
      .OUT_W         (OUT_W)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .q_valid   (q_valid),
      .q_token   (q_token),
      .q_pop     (q_pop),
      .rsp_valid (rsp_tvalid),
      .rsp_data  (rsp_tdata),
      .rsp_ready (rsp_tready)
   );

`ifndef SYNTHESIS
   // A full queue must hold off the request side.
   a_queue_no_overflow: assert property (@(posedge clock) disable iff (reset)
      q_full |-> !req_tready)
      else $error("character queue accepted an item while full");

   // A rejected frame reports no fields and no tag match.
   a_reject_is_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[0] |-> rsp_tdata[FCW+1:1] == '0)
      else $error("rejected frame carries a field count or a tag match");

   // The field count never passes its limit.
   a_count_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> int'(rsp_tdata[FCW:1]) <= MAX_FIELDS)
      else $error("field count above its limit");
`endif

endmodule

@@ design/fmfp_front.sv @@
// Front end: takes request items and classifies each character.
module fmfp_front (
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [fmfp_pkg::REQ_DATA_W-1:0] req_tdata,  // [7:0] character, [23:8] signal_strength
   input  logic                          req_tlast,   // last_char
   input  logic                          q_full,
   output logic                          push,
   output fmfp_pkg::token_type           push_token
);
   import fmfp_pkg::*;

   logic [7:0]     chr;
   char_class_type cls;

   assign chr = req_tdata[7:0];

   // Sort the character into the classes the parser acts on.
   always_comb begin
      priority if (chr == CHR_SPACE || (chr >= CHR_TAB && chr <= CHR_CR)) begin
         cls = CLS_SPACE;
      end else if (chr == CHR_OPEN) begin
         cls = CLS_OPEN;
      end else if (chr == CHR_CLOSE) begin
         cls = CLS_CLOSE;
      end else if (chr == CHR_SEP) begin
         cls = CLS_SEP;
      end else if (chr >= CHR_ZERO && chr <= CHR_NINE) begin
         cls = CLS_DIGIT;
      end else if (chr == CHR_PLUS) begin
         cls = CLS_PLUS;
      end else begin
         cls = CLS_OTHER;
      end
   end

   // An item is taken whenever the queue has room.
   assign req_tready          = !q_full;
   assign push                = req_tvalid && !q_full;
   assign push_token.chr      = chr;
   assign push_token.cls      = cls;
   assign push_token.last     = req_tlast;
   assign push_token.strength = req_tdata[23:8];

endmodule

@@ design/fmfp_queue.sv @@
// Short queue of classified characters between the front end and the parser.
module fmfp_queue #(
   parameter int DEPTH = 4
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  fmfp_pkg::token_type push_token,
   output logic                full,
   output logic                out_valid,
   output fmfp_pkg::token_type out_token,
   input  logic                pop
);
   import fmfp_pkg::*;

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
   localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

   token_type       entry_ff [DEPTH];
   logic [AW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]   count_ff, count_in;

   assign full      = count_ff == FULL_CNT;
   assign out_valid = count_ff != '0;
   assign out_token = entry_ff[rd_ptr_ff];

   // Pointer and fill count updates.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + AW'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + AW'(1);
      end
      unique case ({push, pop})
         2'b10:   count_in = count_ff + CW'(1);
         2'b01:   count_in = count_ff - CW'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage needs no reset.
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_token;
      end
   end

endmodule

@@ design/fmfp_back.sv @@
// Back end: frame parser, tag match, date fields and the result register.
module fmfp_back #(
   parameter int MAX_FIELDS    = 16,
   parameter int FIELD_BUFFER  = 16,
   parameter int PATTERN_CHARS = 8,
   parameter int OUT_W         = 72
) (
   input  logic                clock,
   input  logic                reset,
   input  fmfp_pkg::cfg_type   cfg,
   input  logic                q_valid,
   input  fmfp_pkg::token_type q_token,
   output logic                q_pop,
   output logic                rsp_valid,
   output logic [OUT_W-1:0]    rsp_data,
   input  logic                rsp_ready
);
   import fmfp_pkg::*;

   localparam int FCW = $clog2(MAX_FIELDS + 1);
   localparam int CCW = $clog2(FIELD_BUFFER);
   localparam int TW  = 8 * PATTERN_CHARS;
   localparam logic [FCW-1:0] MAX_IDX   = FCW'(MAX_FIELDS);
   localparam logic [CCW-1:0] CNT_LIMIT = CCW'(FIELD_BUFFER - 1);

   typedef enum logic [1:0] {PH_WAIT, PH_FIELDS, PH_DONE} phase_type;
   typedef enum logic [1:0] {NP_LEAD, NP_DIGITS, NP_DONE} num_phase_type;

   phase_type      phase_ff, phase_in;
   num_phase_type  num_phase_ff, num_phase_in;
   logic [FCW-1:0] field_idx_ff, field_idx_in;
   logic [CCW-1:0] char_cnt_ff, char_cnt_in;
   logic           after_sep_ff, after_sep_in;
   logic           sep_seen_ff, sep_seen_in;
   logic           err_ff, err_in;
   logic [7:0]     last_vis_ff, last_vis_in;
   logic [TW-1:0]  tag_text_ff, tag_text_in;
   logic           tag_mismatch_ff, tag_mismatch_in;
   logic [15:0]    acc_ff, acc_in;
   logic [15:0]    pending_ff [DATE_FIELDS];
   logic [15:0]    pending_in [DATE_FIELDS];
   logic [15:0]    year_ff, year_in;
   logic [7:0]     parts_ff [DATE_PARTS];
   logic [7:0]     parts_in [DATE_PARTS];
   logic           rsp_valid_ff;
   logic [OUT_W-1:0] rsp_data_ff;

   logic           out_free;
   logic           pop;
   logic           tag_ok;
   logic [19:0]    prod;
   logic [15:0]    acc_step;
   logic           ok_in;
   logic           matched_in;
   logic [FCW-1:0] count_out;

   // A character that ends a message needs room in the result register.
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign pop      = q_valid && (!q_token.last || out_free);
   assign q_pop    = pop;

   // Decimal accumulate with saturation at the 16-bit limit.
   assign prod = {1'b0, acc_ff, 3'b000} + {3'b000, acc_ff, 1'b0} + {16'd0, q_token.chr[3:0]};
   assign acc_step = (|prod[19:16]) ? 16'hFFFF : prod[15:0];

   // Tag compare against the configured pattern, '*' matches anything.
   always_comb begin
      tag_ok = (cfg.pattern_len != '0) && (int'(cfg.pattern_len) <= PATTERN_CHARS) &&
               (int'(char_cnt_ff) == int'(cfg.pattern_len));
      for (int i = 0; i < PATTERN_CHARS; i++) begin
         if (i < int'(cfg.pattern_len) && cfg.pattern[8*i +: 8] != CHR_STAR &&
             cfg.pattern[8*i +: 8] != tag_text_ff[8*i +: 8]) begin
            tag_ok = 1'b0;
         end
      end
   end

   // Next frame state for the character at the head of the queue.
   always_comb begin
      logic ws;
      logic close_req;
      logic count_req;
      logic text_req;

      ws        = q_token.cls == CLS_SPACE;
      close_req = 1'b0;
      count_req = 1'b0;
      text_req  = 1'b0;

      phase_in        = phase_ff;
      num_phase_in    = num_phase_ff;
      field_idx_in    = field_idx_ff;
      char_cnt_in     = char_cnt_ff;
      after_sep_in    = after_sep_ff;
      sep_seen_in     = sep_seen_ff;
      err_in          = err_ff;
      last_vis_in     = last_vis_ff;
      tag_text_in     = tag_text_ff;
      tag_mismatch_in = tag_mismatch_ff;
      acc_in          = acc_ff;
      pending_in      = pending_ff;

      if (!ws) begin
         last_vis_in = q_token.chr;
      end

      // Framing: open mark, fields and separators, then nothing after the close mark.
      unique case (phase_ff)
         PH_WAIT: begin
            if (!ws) begin
               if (q_token.cls == CLS_OPEN) begin
                  phase_in = PH_FIELDS;
               end else begin
                  err_in   = 1'b1;
                  phase_in = PH_DONE;
               end
            end
         end
         PH_FIELDS: begin
            if (q_token.cls == CLS_CLOSE) begin
               close_req = 1'b1;
               count_req = !after_sep_ff;
               phase_in  = PH_DONE;
            end else if (q_token.cls == CLS_SEP && !after_sep_ff) begin
               if (field_idx_ff == '0 && char_cnt_ff == '0) begin
                  err_in = 1'b1;
               end
               close_req    = 1'b1;
               count_req    = 1'b1;
               after_sep_in = 1'b1;
               sep_seen_in  = 1'b1;
            end else begin
               text_req     = 1'b1;
               after_sep_in = 1'b0;
            end
         end
         default: begin
         end
      endcase

      // Closing a field: tag check on the first one, date capture on the next five.
      if (close_req) begin
         if (field_idx_ff == '0) begin
            tag_mismatch_in = !tag_ok;
         end
         for (int k = 0; k < DATE_FIELDS; k++) begin
            if (int'(field_idx_ff) == k + 1) begin
               pending_in[k] = acc_ff;
            end
         end
         char_cnt_in  = '0;
         acc_in       = '0;
         num_phase_in = NP_LEAD;
      end

      if (count_req && field_idx_ff < MAX_IDX) begin
         field_idx_in = field_idx_ff + FCW'(1);
      end

      // Text character: tag capture and number reading within the field buffer.
      if (text_req && char_cnt_ff < CNT_LIMIT) begin
         if (field_idx_ff == '0) begin
            for (int i = 0; i < PATTERN_CHARS; i++) begin
               if (int'(char_cnt_ff) == i) begin
                  tag_text_in[8*i +: 8] = q_token.chr;
               end
            end
         end
         unique case (num_phase_ff)
            NP_LEAD: begin
               if (q_token.cls == CLS_PLUS) begin
                  num_phase_in = NP_DIGITS;
               end else if (q_token.cls == CLS_DIGIT) begin
                  num_phase_in = NP_DIGITS;
                  acc_in       = acc_step;
               end else if (!ws) begin
                  num_phase_in = NP_DONE;
               end
            end
            NP_DIGITS: begin
               if (q_token.cls == CLS_DIGIT) begin
                  acc_in = acc_step;
               end else begin
                  num_phase_in = NP_DONE;
               end
            end
            default: begin
            end
         endcase
         char_cnt_in = char_cnt_ff + CCW'(1);
      end

      // Verdict for a message that ends with this character.
      ok_in = !err_in && phase_in == PH_DONE && last_vis_in == CHR_CLOSE && sep_seen_in;
      matched_in = ok_in && !tag_mismatch_in;
      count_out  = ok_in ? field_idx_in : '0;
      year_in    = year_ff;
      parts_in   = parts_ff;
      if (matched_in) begin
         year_in = pending_in[0];
         for (int k = 0; k < DATE_PARTS; k++) begin
            parts_in[k] = (|pending_in[k+1][15:8]) ? 8'hFF : pending_in[k+1][7:0];
         end
      end
   end

   // Frame state, stored date-time and the result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= PH_WAIT;
         num_phase_ff    <= NP_LEAD;
         field_idx_ff    <= '0;
         char_cnt_ff     <= '0;
         after_sep_ff    <= 1'b0;
         sep_seen_ff     <= 1'b0;
         err_ff          <= 1'b0;
         last_vis_ff     <= '0;
         tag_text_ff     <= '0;
         tag_mismatch_ff <= 1'b0;
         acc_ff          <= '0;
         year_ff         <= '0;
         for (int k = 0; k < DATE_FIELDS; k++) begin
            pending_ff[k] <= '0;
         end
         for (int k = 0; k < DATE_PARTS; k++) begin
            parts_ff[k] <= '0;
         end
         rsp_valid_ff    <= 1'b0;
      end else begin
         if (pop) begin
            if (q_token.last) begin
               phase_ff        <= PH_WAIT;
               num_phase_ff    <= NP_LEAD;
               field_idx_ff    <= '0;
               char_cnt_ff     <= '0;
               after_sep_ff    <= 1'b0;
               sep_seen_ff     <= 1'b0;
               err_ff          <= 1'b0;
               last_vis_ff     <= '0;
               tag_text_ff     <= '0;
               tag_mismatch_ff <= 1'b0;
               acc_ff          <= '0;
               for (int k = 0; k < DATE_FIELDS; k++) begin
                  pending_ff[k] <= '0;
               end
               year_ff  <= year_in;
               parts_ff <= parts_in;
               rsp_data_ff <= OUT_W'({q_token.strength, parts_in[3], parts_in[2], parts_in[1],
                                      parts_in[0], year_in, matched_in, count_out, ok_in});
            end else begin
               phase_ff        <= phase_in;
               num_phase_ff    <= num_phase_in;
               field_idx_ff    <= field_idx_in;
               char_cnt_ff     <= char_cnt_in;
               after_sep_ff    <= after_sep_in;
               sep_seen_ff     <= sep_seen_in;
               err_ff          <= err_in;
               last_vis_ff     <= last_vis_in;
               tag_text_ff     <= tag_text_in;
               tag_mismatch_ff <= tag_mismatch_in;
               acc_ff          <= acc_in;
               pending_ff      <= pending_in;
            end
         end
         if (pop && q_token.last) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
